>>> rtl/gdt_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal package
// Shared sizes, the control state type and the row scan result for the
// depth-first / breadth-first traversal unit.
// ----------------------------------------------------------------------------
package gdt_pkg;

   // Graph size and derived widths.
   localparam int NODES     = 256;
   localparam int NODE_W    = 9;                       // node number 0..NODES
   localparam int IDX_W     = $clog2(NODES);           // node number minus one
   localparam int ROW_WORDS = (NODES + 63) / 64;       // 64-bit words per row
   localparam int WORD_W    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int ADJ_DEPTH = NODES * ROW_WORDS;
   localparam int ADJ_AW    = $clog2(ADJ_DEPTH);

   // Request modes.
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_NEXT    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   // Register indexes.
   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_KIND       = 1'b1;

   // Control states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_WR,
      ST_PTR,
      ST_NODE,
      ST_SCAN,
      ST_RESP
   } state_type;

   // Outcome of scanning one adjacency word.
   typedef struct packed {
      logic              beyond;   // word starts past the active node count
      logic              hit;      // an unvisited neighbor was found
      logic              last;     // no further word of this row is in range
      logic [5:0]        bit_idx;  // bit of the neighbor inside the word
      logic [NODE_W-1:0] node;     // neighbor node number
   } scan_type;

endpackage

>>> rtl/gdt_if.sv
// ----------------------------------------------------------------------------
// Traversal channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface gdt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [8:0] edge_source;
   logic [8:0] edge_target;

   modport source (output valid, mode, edge_source, edge_target, input ready);
   modport sink   (input valid, mode, edge_source, edge_target, output ready);
endinterface

interface gdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] visited_node;
   logic       finished;

   modport source (output valid, visited_node, finished, input ready);
   modport sink   (input valid, visited_node, finished, output ready);
endinterface

>>> rtl/gdt_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gdt_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 9
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

>>> rtl/gdt_scan.sv
// ----------------------------------------------------------------------------
// Adjacency word scanner
// Masks one row word with the visited marks and the active node range and
// finds the lowest remaining neighbor.
// ----------------------------------------------------------------------------
module gdt_scan
   import gdt_pkg::*;
(
   input  logic [63:0]       adj_word,
   input  logic [63:0]       vis_word,
   input  logic [WORD_W-1:0] word,
   input  logic [NODE_W-1:0] count,
   output scan_type          result
);

   logic [NODE_W+1:0] base;
   logic [NODE_W+1:0] diff;
   logic [63:0]       mask;
   logic [63:0]       bits;
   logic [5:0]        idx;

   always_comb begin
      base = (NODE_W+2)'(word) << 6;
      diff = (NODE_W+2)'(count) - base;

      // Only targets up to the active node count take part.
      if (diff < (NODE_W+2)'(64)) begin
         mask = (64'd1 << diff[5:0]) - 64'd1;
      end else begin
         mask = '1;
      end
      bits = adj_word & ~vis_word & mask;

      // Lowest set bit.
      idx = '0;
      for (int b = 63; b >= 0; b--) begin
         if (bits[b]) begin
            idx = 6'(b);
         end
      end

      result.beyond  = (base >= (NODE_W+2)'(count));
      result.hit     = (bits != 64'd0);
      result.last    = (word == WORD_W'(ROW_WORDS - 1)) ||
                       (base + (NODE_W+2)'(64) >= (NODE_W+2)'(count));
      result.bit_idx = idx;
      result.node    = NODE_W'(base) + NODE_W'(idx) + NODE_W'(1);
   end

endmodule

>>> rtl/graph_dfs_bfs_traversal_unit.sv
// ----------------------------------------------------------------------------
// Graph depth-first / breadth-first traversal unit
// Loads directed edges into an adjacency bit matrix and returns nodes in
// depth-first or breadth-first visit order, lowest neighbor first.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   -------  ---------  ------------------------------------------
//   req_bus  in         mode, edge_source, edge_target
//   rsp_bus  out        visited_node, finished (one per next-node request)
//   csr_*    in         node_count (index 0), traversal_kind (index 1)
//
// An edge load is a read-modify-write of one adjacency word; an ignored edge, an
// unused mode or a restart is handled in the idle state. A next-node request
// fetches the stack top or queue head and scans its row word by word, popping a
// stack level or retiring a queue entry per exhausted row; the first one after a
// restart returns node 1. After reset all 1024 adjacency words are cleared, one
// per cycle, while requests wait. A pending result stalls only the next result.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_traversal_unit
   import gdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gdt_req_if.sink     req_bus,
   gdt_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);

   // Registers.
   state_type                      state_ff, state_in;
   logic [ADJ_AW-1:0]              clr_ff, clr_in;
   logic [NODE_W-1:0]              node_count_ff;
   logic                           kind_ff;
   logic                           started_ff, started_in;
   logic [NODE_W-1:0]              sp_ff, sp_in;
   logic [NODE_W-1:0]              head_ff, head_in;
   logic [NODE_W-1:0]              tail_ff, tail_in;
   logic [ROW_WORDS-1:0][63:0]     vis_ff, vis_in;
   logic [IDX_W-1:0]               src_ff, src_in;
   logic [IDX_W-1:0]               tgt_ff, tgt_in;
   logic [IDX_W-1:0]               node_ff, node_in;
   logic [WORD_W-1:0]              word_ff, word_in;
   logic [NODE_W-1:0]              res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]              rsp_node_ff, rsp_node_in;

   // Memory ports.
   logic              adj_we;
   logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
   logic [63:0]       adj_wdata, adj_rdata;
   logic              stk_we, que_we;
   logic [IDX_W-1:0]  stk_waddr, stk_raddr, que_waddr, que_raddr;
   logic [NODE_W-1:0] stk_wdata, stk_rdata, que_wdata, que_rdata;

   logic [NODE_W-1:0] count;
   logic [NODE_W-1:0] nd;
   logic [IDX_W-1:0]  nd_idx;
   logic              src_ok, tgt_ok, accept;
   scan_type          scan;

   gdt_ram #(.DEPTH(ADJ_DEPTH), .WIDTH(64)) u_adj (
      .clock(clock), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
      .raddr(adj_raddr), .rdata(adj_rdata));

   gdt_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata));

   gdt_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_queue (
      .clock(clock), .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
      .raddr(que_raddr), .rdata(que_rdata));

   gdt_scan u_scan (
      .adj_word(adj_rdata), .vis_word(vis_ff[word_ff]), .word(word_ff),
      .count(count), .result(scan));

   // Active node count, clamped to 1..NODES.
   always_comb begin
      if (node_count_ff == '0) begin
         count = NODE_W'(1);
      end else if (node_count_ff > NODE_W'(NODES)) begin
         count = NODE_W'(NODES);
      end else begin
         count = node_count_ff;
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.visited_node = rsp_node_ff;
   assign rsp_bus.finished     = (rsp_node_ff == '0);

   assign accept = req_bus.valid && (state_ff == ST_IDLE);
   assign src_ok = (req_bus.edge_source != '0) && (req_bus.edge_source <= count);
   assign tgt_ok = (req_bus.edge_target != '0) && (req_bus.edge_target <= count);
   assign nd     = kind_ff ? que_rdata : stk_rdata;
   assign nd_idx = IDX_W'(nd - NODE_W'(1));

   // Next state and memory control.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      started_in   = started_ff;
      sp_in        = sp_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      vis_in       = vis_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      node_in      = node_ff;
      word_in      = word_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_node_in  = rsp_node_ff;
      adj_we       = 1'b0;
      adj_waddr    = {src_ff, tgt_ff[IDX_W-1 -: WORD_W]};
      adj_wdata    = adj_rdata | (64'd1 << tgt_ff[5:0]);
      adj_raddr    = {node_ff, word_ff};
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[IDX_W-1:0];
      stk_wdata    = scan.node;
      stk_raddr    = IDX_W'(sp_ff - NODE_W'(1));
      que_we       = 1'b0;
      que_waddr    = tail_ff[IDX_W-1:0];
      que_wdata    = scan.node;
      que_raddr    = head_ff[IDX_W-1:0];

      unique case (state_ff)
         // Zero the adjacency matrix after reset.
         ST_CLEAR: begin
            adj_we    = 1'b1;
            adj_waddr = clr_ff;
            adj_wdata = '0;
            clr_in    = clr_ff + ADJ_AW'(1);
            if (clr_ff == ADJ_AW'(ADJ_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take a request.
         ST_IDLE: begin
            if (accept) begin
               priority case (req_bus.mode)
                  MODE_LOAD: begin
                     if (src_ok && tgt_ok) begin
                        src_in   = IDX_W'(req_bus.edge_source - 9'd1);
                        tgt_in   = IDX_W'(req_bus.edge_target - 9'd1);
                        state_in = ST_EDGE_RD;
                     end
                  end
                  MODE_RESTART: begin
                     vis_in     = '0;
                     head_in    = '0;
                     tail_in    = '0;
                     sp_in      = '0;
                     started_in = 1'b0;
                  end
                  MODE_NEXT: begin
                     if (!started_ff) begin
                        // First visit: node 1 seeds both stack and queue.
                        started_in   = 1'b1;
                        vis_in[0][0] = 1'b1;
                        stk_we       = 1'b1;
                        stk_waddr    = '0;
                        stk_wdata    = NODE_W'(1);
                        que_we       = 1'b1;
                        que_waddr    = '0;
                        que_wdata    = NODE_W'(1);
                        sp_in        = NODE_W'(1);
                        head_in      = '0;
                        tail_in      = NODE_W'(1);
                        res_in       = NODE_W'(1);
                        state_in     = ST_RESP;
                     end else begin
                        state_in = ST_PTR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Edge load: read the word, then set the target bit.
         ST_EDGE_RD: begin
            adj_raddr = {src_ff, tgt_ff[IDX_W-1 -: WORD_W]};
            state_in  = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            adj_we   = 1'b1;
            state_in = ST_IDLE;
         end

         // Fetch the node on top of the stack or at the queue head.
         ST_PTR: begin
            if (!kind_ff ? (sp_ff != '0) : (head_ff < tail_ff)) begin
               state_in = ST_NODE;
            end else begin
               res_in   = '0;
               state_in = ST_RESP;
            end
         end

         // Start the row scan at its first word.
         ST_NODE: begin
            node_in   = nd_idx;
            word_in   = '0;
            adj_raddr = {nd_idx, WORD_W'(0)};
            state_in  = ST_SCAN;
         end

         // Examine one row word per cycle.
         ST_SCAN: begin
            if (!scan.beyond && scan.hit) begin
               vis_in[word_ff][scan.bit_idx] = 1'b1;
               if (!kind_ff) begin
                  if (sp_ff < NODE_W'(NODES)) begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + NODE_W'(1);
                  end
               end else begin
                  if (tail_ff < NODE_W'(NODES)) begin
                     que_we  = 1'b1;
                     tail_in = tail_ff + NODE_W'(1);
                  end
               end
               res_in   = scan.node;
               state_in = ST_RESP;
            end else if (!scan.beyond && !scan.last) begin
               word_in   = word_ff + WORD_W'(1);
               adj_raddr = {node_ff, word_ff + WORD_W'(1)};
            end else begin
               // Row exhausted: pop the stack or retire the queue head.
               if (!kind_ff) begin
                  sp_in = sp_ff - NODE_W'(1);
               end else begin
                  head_in = head_ff + NODE_W'(1);
               end
               state_in = ST_PTR;
            end
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= NODE_W'(1);
         kind_ff       <= 1'b0;
         started_ff    <= 1'b0;
         sp_ff         <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         vis_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         started_ff   <= started_in;
         sp_ff        <= sp_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         vis_ff       <= vis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NODE_COUNT: node_count_ff <= csr_data;
               CSR_KIND:       kind_ff       <= csr_data[0];
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      node_ff     <= node_in;
      word_ff     <= word_in;
      res_ff      <= res_in;
      rsp_node_ff <= rsp_node_in;
   end

endmodule
